// ===== sv/sha_pkg.sv =====
package sha_pkg;

  localparam int unsigned BlkWords = 16;
  localparam int unsigned HashWords = 8;
  localparam int unsigned Rounds = 64;

  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StLoad   = 8'b0000_0010,
    StRound  = 8'b0000_0100,
    StAdd    = 8'b0000_1000,
    StLen    = 8'b0001_0000,
    StClear  = 8'b0010_0000,
    StEmit   = 8'b0100_0000,
    StInit   = 8'b1000_0000
  } state_e;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428A2F98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hB5C0FBCF;
      6'd3: k = 32'hE9B5DBA5; 6'd4: k = 32'h3956C25B; 6'd5: k = 32'h59F111F1;
      6'd6: k = 32'h923F82A4; 6'd7: k = 32'hAB1C5ED5; 6'd8: k = 32'hD807AA98;
      6'd9: k = 32'h12835B01; 6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
      6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
      6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
      6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
      6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
      6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
      6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
      6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
      6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
      default: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

  function automatic word_t start_h(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6A09E667; 3'd1: h = 32'hBB67AE85;
      3'd2: h = 32'h3C6EF372; 3'd3: h = 32'hA54FF53A;
      3'd4: h = 32'h510E527F; 3'd5: h = 32'h9B05688C;
      3'd6: h = 32'h1F83D9AB;
      default: h = 32'h5BE0CD19;
    endcase
    return h;
  endfunction

endpackage

// ===== sv/sha_ram.sv =====
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/sha_round.sv =====
module sha_round import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       step_i,
  input  word_t      hin_i [HashWords],
  input  word_t      w_i,
  input  logic [5:0] t_i,
  output word_t      v_o [HashWords]
);

  word_t v_q [HashWords];
  word_t a, e, s0, s1, ch, maj, t1, t2;

  always_comb begin
    a   = v_q[0];
    e   = v_q[4];
    s1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    ch  = (e & v_q[5]) ^ (~e & v_q[6]);
    t1  = v_q[7] + s1 + ch + round_k(t_i) + w_i;
    s0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    maj = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = s0 + maj;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      v_q <= hin_i;
    end else if (step_i) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

  assign v_o = v_q;

endmodule

// ===== sv/sha256_stream_hasher.sv =====
// sha-256 over a byte stream
// input channel (in_valid_i / in_ready_o): cmd_i = 0 appends data_byte_i to the
// message, cmd_i = 1 finishes it. in_ready_o stays high after a data item
// unless it completes a 64-byte block; that item and a finish start the compression.
// during one block in_ready_o is low: the 16 block words are read from a ram,
// then 64 rounds run one per cycle with the message schedule kept in a 16-word
// shift window, then the hash is added and the block ram cleared.
// a finish writes the bit length, runs one compression (two when eight or fewer
// bytes are left in the block) and clears the block ram again before the first
// digest word appears. the eight words follow, word_index_o 0 first, last_word_o
// high on word 7, one per cycle while out_ready_i is high.
// each result item waits on the output channel (out_valid_o / out_ready_i)
// until taken; a stalled receiver holds the block with no loss.
// after the last digest word, hash and block state reset for the next message
// before in_ready_o rises. after reset the block clears the block ram before
// in_ready_o rises.
module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  state_e     state_q, state_d;
  logic [60:0] count_q;
  logic [6:0] t_q;
  logic       fin_q;
  logic       second_q;
  logic [2:0] oidx_q;
  word_t      h_q [HashWords];
  word_t      w_q [BlkWords];
  word_t      blk_q;

  // block ram: byte read-modify-write is done in a shadow word register
  logic       we;
  logic [3:0] waddr, raddr;
  word_t      wdata, rdata;

  sha_ram #(.Width(32), .Depth(BlkWords)) u_blk (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  word_t v [HashWords];
  word_t wcur, x15, y2, sig0, sig1, wnext;
  logic  rload, rstep;

  sha_round u_round (
    .clk_i, .load_i(rload), .step_i(rstep), .hin_i(h_q), .w_i(wcur),
    .t_i(t_q[5:0] - 6'd1), .v_o(v)
  );

  logic [5:0] pos;
  logic       accept;
  assign pos = count_q[5:0];
  assign in_ready_o = (state_q == StIdle);
  assign accept = in_valid_i && in_ready_o;

  // current word being filled lives in blk_q; written to ram when full or on a finish
  always_comb begin
    x15   = w_q[1];
    y2    = w_q[14];
    sig0  = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
    sig1  = {y2[16:0], y2[31:17]} ^ {y2[18:0], y2[31:19]} ^ (y2 >> 10);
    wnext = sig1 + w_q[9] + sig0 + w_q[0];
    wcur  = w_q[0];
  end

  word_t byte_word;
  logic [7:0] bval;
  always_comb begin
    bval = (accept && !cmd_i) ? data_byte_i : PadByte;
    byte_word = blk_q | ({24'd0, bval} << (5'd24 - {pos[1:0], 3'd0}));
  end

  logic [63:0] bits;
  assign bits = {count_q, 3'b000};

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    waddr = pos[5:2];
    wdata = byte_word;
    raddr = t_q[3:0];
    rload = 1'b0;
    rstep = 1'b0;
    case (state_q)
      StInit, StClear: begin
        we = 1'b1;
        waddr = t_q[3:0];
        wdata = '0;
        if (t_q[3:0] == 4'd15) state_d = (state_q == StClear) ? StEmit : StIdle;
      end
      StIdle: begin
        if (accept) begin
          if (pos[1:0] == 2'd3 || cmd_i) we = 1'b1;
          if (cmd_i) begin
            state_d = (pos >= 6'd56) ? StLoad : StLen;
          end else if (pos == 6'd63) begin
            state_d = StLoad;
          end
        end
      end
      StLen: begin
        we = 1'b1;
        waddr = t_q[0] ? 4'd15 : 4'd14;
        wdata = t_q[0] ? bits[31:0] : bits[63:32];
        if (t_q[0]) state_d = StLoad;
      end
      StLoad: begin
        if (t_q[4:0] == 5'd16) begin
          rload = 1'b1;
          state_d = StRound;
        end
      end
      StRound: begin
        rstep = 1'b1;
        if (t_q == 7'd64) state_d = StAdd;
      end
      StAdd: begin
        we = 1'b1;
        waddr = t_q[3:0];
        wdata = '0;
        if (t_q[3:0] == 4'd15) begin
          if (!fin_q) state_d = StIdle;
          else if (second_q) state_d = StLen;
          else state_d = StClear;
        end
      end
      StEmit: begin
        if (out_ready_i && oidx_q == 3'd7) state_d = StInit;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StInit;
      count_q  <= '0;
      t_q      <= '0;
      fin_q    <= 1'b0;
      second_q <= 1'b0;
      oidx_q   <= '0;
      blk_q    <= '0;
      for (int i = 0; i < HashWords; i++) h_q[i] <= start_h(3'(i));
    end else begin
      state_q <= state_d;
      case (state_q)
        StInit: begin
          t_q <= (t_q[3:0] == 4'd15) ? 7'd0 : t_q + 7'd1;
          blk_q <= '0;
          count_q <= '0;
          fin_q <= 1'b0;
          oidx_q <= '0;
          for (int i = 0; i < HashWords; i++) h_q[i] <= start_h(3'(i));
        end
        StClear: t_q <= (t_q[3:0] == 4'd15) ? 7'd0 : t_q + 7'd1;
        StIdle: begin
          t_q <= '0;
          if (accept) begin
            if (cmd_i) begin
              fin_q <= 1'b1;
              second_q <= (pos >= 6'd56);
              blk_q <= '0;
            end else begin
              count_q <= count_q + 61'd1;
              blk_q <= (pos[1:0] == 2'd3) ? '0 : byte_word;
            end
          end
        end
        StLen: t_q <= t_q[0] ? 7'd0 : 7'd1;
        StLoad: begin
          // ram data of address t-1 arrives; shift into schedule window
          if (t_q != 7'd0) begin
            for (int i = 0; i < BlkWords - 1; i++) w_q[i] <= w_q[i+1];
            w_q[15] <= rdata;
          end
          t_q <= (t_q[4:0] == 5'd16) ? 7'd1 : t_q + 7'd1;
        end
        StRound: begin
          // window holds w[r]..w[r+15]; round r uses w_q[0], w[r+16] enters at the top
          for (int i = 0; i < BlkWords - 1; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wnext;
          t_q <= (t_q == 7'd64) ? 7'd0 : t_q + 7'd1;
        end
        StAdd: begin
          t_q <= (t_q[3:0] == 4'd15) ? 7'd0 : t_q + 7'd1;
          // the working words are final once the last round has been taken
          if (t_q[3:0] == 4'd0) begin
            for (int i = 0; i < HashWords; i++) h_q[i] <= h_q[i] + v[i];
          end
          if (t_q[3:0] == 4'd15 && fin_q) second_q <= 1'b0;
        end
        StEmit: if (out_ready_i) oidx_q <= oidx_q + 3'd1;
        default: ;
      endcase
    end
  end

  // at load w_q[0..15] holds w[0]..w[15], so each step reads w_q[0]
  assign out_valid_o   = (state_q == StEmit);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

endmodule
